// ===== rtl/core/fde_pkg.sv =====
// Shared types, command codes and shape tables for the framebuffer draw engine.
// No dependencies; every other file of the engine but fde_ram imports this package.
package fde_pkg;

    localparam int KIND_W  = 3;
    localparam int COORD_W = 13;
    localparam int COLOR_W = 16;
    localparam int MASK_W  = 16;
    localparam int FONT_W  = 5;
    localparam int POS_W   = 12;
    localparam int OP_W    = 3;
    localparam int STEP_W  = 3;

    localparam logic [FONT_W-1:0] FONT_WIDTH_RESET = 5'd8;
    localparam logic [FONT_W-1:0] GLYPH_COLS_MAX   = 5'd16;

    // Command kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_FILL    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIAMOND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GLYPH   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

    // Work codes passed from the front end to the back end
    localparam logic [OP_W-1:0] OP_ACK   = 3'd0;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DIAM  = 3'd2;
    localparam logic [OP_W-1:0] OP_GLYPH = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    localparam logic [STEP_W-1:0] DIAMOND_LAST = 3'd5;

    typedef logic [COORD_W-1:0] coord_t;

    // One classified command: region bounds are end-exclusive
    typedef struct packed {
        logic [OP_W-1:0]    op;
        coord_t             x0;
        coord_t             y0;
        coord_t             xe;
        coord_t             ye;
        logic [COLOR_W-1:0] color;
        logic [MASK_W-1:0]  mask;
    } desc_t;

    function automatic coord_t coord_min(input coord_t a, input coord_t b);
        coord_min = (a < b) ? a : b;
    endfunction

    // Diamond row start offset
    function automatic coord_t diamond_off(input logic [STEP_W-1:0] step);
        case (step)
            3'd0:    diamond_off = 13'd2;
            3'd1:    diamond_off = 13'd1;
            3'd2:    diamond_off = 13'd0;
            3'd3:    diamond_off = 13'd0;
            3'd4:    diamond_off = 13'd1;
            default: diamond_off = 13'd2;
        endcase
    endfunction

    // Diamond row span end offset (start offset plus length)
    function automatic coord_t diamond_end(input logic [STEP_W-1:0] step);
        case (step)
            3'd0:    diamond_end = 13'd4;
            3'd1:    diamond_end = 13'd5;
            3'd2:    diamond_end = 13'd6;
            3'd3:    diamond_end = 13'd6;
            3'd4:    diamond_end = 13'd5;
            default: diamond_end = 13'd4;
        endcase
    endfunction

endpackage

// ===== rtl/core/fde_if.sv =====
// Valid/ready channel interfaces for draw commands and their results.
// Depends on fde_pkg for field widths.
interface fde_cmd_if;
    import fde_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   rect_width;
    logic [POS_W-1:0]   rect_height;
    logic [COLOR_W-1:0] pixel_color;
    logic [MASK_W-1:0]  glyph_bits;

    modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height,
                    pixel_color, glyph_bits, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, rect_width, rect_height,
                    pixel_color, glyph_bits, output ready);
endinterface

interface fde_rsp_if;
    import fde_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] read_value;
    logic               read_in_range;

    modport source (output valid, read_value, read_in_range, input ready);
    modport sink   (input valid, read_value, read_in_range, output ready);
endinterface

// ===== rtl/core/fde_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fde_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                   wr_data,
    input  logic                                rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                   rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fde_front.sv =====
// Front end: accepts draw commands and turns each into a work item, clipping rectangle extents.
// Depends on fde_pkg and the fde_cmd_if interface.
module fde_front #(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128
) (
    fde_cmd_if.sink                     cmd,
    input  logic [fde_pkg::FONT_W-1:0]  font_width,
    input  logic                        q_full,
    output logic                        push,
    output fde_pkg::desc_t              push_desc
);
    import fde_pkg::*;

    localparam coord_t W_C = COORD_W'(DISPLAY_WIDTH);
    localparam coord_t H_C = COORD_W'(DISPLAY_HEIGHT);

    coord_t             x;
    coord_t             y;
    coord_t             glyph_cols;
    logic [FONT_W-1:0]  cols_clip;

    // Accept whenever the queue has room
    assign cmd.ready = !q_full;
    assign push      = cmd.valid && !q_full;

    assign x          = {1'b0, cmd.pos_x};
    assign y          = {1'b0, cmd.pos_y};
    assign cols_clip  = (font_width > GLYPH_COLS_MAX) ? GLYPH_COLS_MAX : font_width;
    assign glyph_cols = COORD_W'(cols_clip);

    // Classify the command and clip the extent of a fill, pixel or rectangle
    always_comb
    begin
        push_desc.op    = OP_ACK;
        push_desc.x0    = x;
        push_desc.y0    = y;
        push_desc.xe    = x;
        push_desc.ye    = y;
        push_desc.color = cmd.pixel_color;
        push_desc.mask  = cmd.glyph_bits;
        case (cmd.kind)
            KIND_FILL:
            begin
                push_desc.op = OP_RECT;
                push_desc.x0 = '0;
                push_desc.y0 = '0;
                push_desc.xe = W_C;
                push_desc.ye = H_C;
            end
            KIND_PIXEL:
            begin
                push_desc.op = OP_RECT;
                push_desc.xe = coord_min(x + 13'd1, W_C);
                push_desc.ye = coord_min(y + 13'd1, H_C);
            end
            KIND_RECT:
            begin
                push_desc.op = OP_RECT;
                push_desc.xe = coord_min(x + {1'b0, cmd.rect_width}, W_C);
                push_desc.ye = coord_min(y + {1'b0, cmd.rect_height}, H_C);
            end
            KIND_DIAMOND:
            begin
                push_desc.op = OP_DIAM;
            end
            KIND_GLYPH:
            begin
                push_desc.op = OP_GLYPH;
                push_desc.xe = x + glyph_cols;
            end
            KIND_READ:
            begin
                push_desc.op = OP_READ;
            end
            default:
            begin
                push_desc.op = OP_ACK;
            end
        endcase
    end

endmodule

// ===== rtl/core/fde_queue.sv =====
// Two-entry queue of work items between the front end and the back end.
// Depends on fde_pkg for the work item type.
module fde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fde_pkg::desc_t  push_desc,
    output logic            full,
    input  logic            pop,
    output fde_pkg::desc_t  head,
    output logic            empty
);
    import fde_pkg::*;

    desc_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/core/fde_back.sv =====
// Back end: walks each work item one pixel per cycle into the frame RAM,
// serves reads, and holds the result in an output register.
// Depends on fde_pkg and the fde_rsp_if interface.
module fde_back #(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128,
    parameter int AW             = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  fde_pkg::desc_t               q_head,
    output logic                         q_pop,
    output logic                         ram_wr_en,
    output logic [AW-1:0]                ram_wr_addr,
    output logic [fde_pkg::COLOR_W-1:0]  ram_wr_data,
    output logic                         ram_rd_en,
    output logic [AW-1:0]                ram_rd_addr,
    input  logic [fde_pkg::COLOR_W-1:0]  ram_rd_data,
    fde_rsp_if.source                    rsp
);
    import fde_pkg::*;

    localparam int COL_W = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
    localparam int ROW_W = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;
    localparam coord_t W_C = COORD_W'(DISPLAY_WIDTH);
    localparam coord_t H_C = COORD_W'(DISPLAY_HEIGHT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    desc_t               desc_reg;
    desc_t               desc_next;
    coord_t              row_reg;
    coord_t              row_next;
    coord_t              col_reg;
    coord_t              col_next;
    coord_t              ce_reg;
    coord_t              ce_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-1:0]   mask_next;
    logic                hit_reg;
    logic                hit_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COLOR_W-1:0]  out_value_reg;
    logic [COLOR_W-1:0]  out_value_next;
    logic                out_hit_reg;
    logic                out_hit_next;

    logic                in_range;
    logic                pix_on;
    logic [AW-1:0]       pix_addr;
    coord_t              col_inc;
    coord_t              row_inc;
    logic [STEP_W-1:0]   step_inc;

    assign in_range = (row_reg < H_C) && (col_reg < W_C);
    assign pix_on   = (desc_reg.op == OP_GLYPH) ? mask_reg[MASK_W-1] : 1'b1;
    assign pix_addr = AW'(row_reg[ROW_W-1:0]) * AW'(DISPLAY_WIDTH)
                      + AW'(col_reg[COL_W-1:0]);
    assign col_inc  = col_reg + 13'd1;
    assign row_inc  = row_reg + 13'd1;
    assign step_inc = step_reg + 3'd1;

    // Frame RAM access
    assign ram_wr_en   = (state_reg == S_WALK) && in_range && pix_on;
    assign ram_wr_addr = pix_addr;
    assign ram_wr_data = desc_reg.color;
    assign ram_rd_en   = (state_reg == S_READ) && in_range;
    assign ram_rd_addr = pix_addr;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_value    = out_value_reg;
    assign rsp.read_in_range = out_hit_reg;

    // Sequence one work item
    always_comb
    begin
        state_next     = state_reg;
        desc_next      = desc_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        ce_next        = ce_reg;
        step_next      = step_reg;
        mask_next      = mask_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_hit_next   = out_hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    desc_next = q_head;
                    row_next  = q_head.y0;
                    col_next  = q_head.x0;
                    ce_next   = q_head.xe;
                    step_next = '0;
                    mask_next = q_head.mask;
                    hit_next  = 1'b0;
                    case (q_head.op)
                        OP_RECT:
                        begin
                            state_next = ((q_head.x0 < q_head.xe) && (q_head.y0 < q_head.ye))
                                         ? S_WALK : S_DONE;
                        end
                        OP_GLYPH:
                        begin
                            state_next = (q_head.x0 < q_head.xe) ? S_WALK : S_DONE;
                        end
                        OP_DIAM:
                        begin
                            col_next   = q_head.x0 + diamond_off('0);
                            ce_next    = q_head.x0 + diamond_end('0);
                            state_next = S_WALK;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                mask_next = {mask_reg[MASK_W-2:0], 1'b0};
                col_next  = col_inc;
                // End of a span: next row, next diamond step, or finish
                if (col_inc == ce_reg)
                begin
                    case (desc_reg.op)
                        OP_RECT:
                        begin
                            if (row_inc == desc_reg.ye)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                row_next = row_inc;
                                col_next = desc_reg.x0;
                            end
                        end
                        OP_DIAM:
                        begin
                            if (step_reg == DIAMOND_LAST)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                step_next = step_inc;
                                row_next  = row_inc;
                                col_next  = desc_reg.x0 + diamond_off(step_inc);
                                ce_next   = desc_reg.x0 + diamond_end(step_inc);
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                hit_next   = in_range;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = hit_reg ? ram_rd_data : '0;
                    out_hit_next   = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
        end
    end

    // Walk and result payload
    always_ff @(posedge clk)
    begin
        desc_reg      <= desc_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        ce_reg        <= ce_next;
        step_reg      <= step_next;
        mask_reg      <= mask_next;
        out_value_reg <= out_value_next;
    end

endmodule

// ===== rtl/core/framebuffer_draw_engine_core.sv =====
// RGB565 framebuffer draw engine. A result comes back for every command. A drawing command
// visits the clipped rectangle area, 24 pixels for a diamond, up to 16 for a glyph row, or the
// whole display for a fill. The back end visits one pixel per cycle, the pace of the frame
// RAM's single write port; a two-entry queue keeps commands coming while one is drawn. Reset
// clears control state and sets font_width to 8; frame contents are undefined until written.
module framebuffer_draw_engine_core #(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fde_cmd_if.sink                     cmd,
    fde_rsp_if.source                   rsp,
    input  logic                        cfg_wr_en,
    input  logic [fde_pkg::FONT_W-1:0]  cfg_wr_data
);
    import fde_pkg::*;

    localparam int DEPTH = DISPLAY_WIDTH * DISPLAY_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [FONT_W-1:0]  font_width_reg;
    logic [FONT_W-1:0]  font_width_next;
    logic               q_push;
    desc_t              q_push_desc;
    logic               q_full;
    logic               q_pop;
    desc_t              q_head;
    logic               q_empty;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [COLOR_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [COLOR_W-1:0] ram_rd_data;

    // Font width register
    assign font_width_next = cfg_wr_en ? cfg_wr_data : font_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_width_reg <= FONT_WIDTH_RESET;
        end
        else
        begin
            font_width_reg <= font_width_next;
        end
    end

    fde_front #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_front (
        .cmd        (cmd),
        .font_width (font_width_reg),
        .q_full     (q_full),
        .push       (q_push),
        .push_desc  (q_push_desc)
    );

    fde_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    fde_back #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .AW             (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .rsp         (rsp)
    );

    fde_ram #(
        .DATA_W (COLOR_W),
        .DEPTH  (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/core/fde_checker.sv =====
// Port-level checks for the draw engine, bound to the top level.
// Depends on fde_pkg and framebuffer_draw_engine_core.
module fde_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [fde_pkg::COLOR_W-1:0] read_value,
    input logic                        read_in_range
);
    import fde_pkg::*;

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       cmd_fire;
    logic       rsp_fire;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Track items accepted but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_fire && !rsp_fire)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (rsp_fire && !cmd_fire)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value)
                                    && $stable(read_in_range))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !read_in_range |-> read_value == '0)
        else $error("nonzero value without an in-range read");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> pend_reg != 3'd0)
        else $error("result with no outstanding item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd4)
        else $error("more items outstanding than the engine can hold");

endmodule

bind framebuffer_draw_engine_core fde_checker u_fde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .read_value    (rsp.read_value),
    .read_in_range (rsp.read_in_range)
);

// ===== tb/tb_framebuffer_draw_engine_core.sv =====
// Self-checking testbench for framebuffer_draw_engine_core: random and directed draw commands,
// a shadow framebuffer that predicts every result, and randomized stalls on both channels.
// Depends on fde_pkg, the fde_cmd_if / fde_rsp_if interfaces and the engine RTL.
`timescale 1ns / 1ps

module tb_framebuffer_draw_engine_core;
    import fde_pkg::*;

    localparam int DISP_W         = 160;
    localparam int DISP_H         = 128;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_HALF = 40;
    localparam int RSP_STALL_LEN  = 400;
    localparam int WATCHDOG_LIMIT = 100000;

    // Kinds that the engine ignores apart from the acknowledgement
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Diamond rows: start offset and span length
    localparam int DIAMOND_OFF [6] = '{2, 1, 0, 0, 1, 2};
    localparam int DIAMOND_LEN [6] = '{2, 4, 6, 6, 4, 2};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   rect_width;
        logic [POS_W-1:0]   rect_height;
        logic [COLOR_W-1:0] pixel_color;
        logic [MASK_W-1:0]  glyph_bits;
    } draw_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] value;
        logic               in_range;
    } read_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [FONT_W-1:0] cfg_wr_data;

    fde_cmd_if cmd_ch ();
    fde_rsp_if rsp_ch ();

    // Shadow framebuffer and font width seen by the predictor
    logic [COLOR_W-1:0] frame_mem [DISP_W*DISP_H];
    logic [FONT_W-1:0]  font_width_q;

    draw_cmd_t    draw_cmds_pending [$];
    read_result_t read_results_due  [$];

    // Command driver state
    draw_cmd_t cmd_cur;
    bit        cmd_taken;
    bit        cmd_burst;
    int        cmd_gap;

    // Result receiver state
    bit        rsp_burst;
    int        rsp_wait;
    int        rsp_stall_left;
    int        rsp_stall_reqs;
    int        rsp_stall_seen;

    int        mismatch_count;
    int        idle_cycles;
    logic [POS_W-1:0] last_draw_x;
    logic [POS_W-1:0] last_draw_y;

    framebuffer_draw_engine_core #(
        .DISPLAY_WIDTH  (DISP_W),
        .DISPLAY_HEIGHT (DISP_H)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock generation
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Write one pixel, dropping it outside the display
    function automatic void plot_pixel(int x, int y, logic [COLOR_W-1:0] color);
        if (x < DISP_W && y < DISP_H)
            frame_mem[y*DISP_W + x] = color;
    endfunction

    // Fill a clipped, end-exclusive block
    function automatic void paint_block(int x, int y, int w, int h, logic [COLOR_W-1:0] color);
        int xe;
        int ye;
        xe = (x + w > DISP_W) ? DISP_W : x + w;
        ye = (y + h > DISP_H) ? DISP_H : y + h;
        for (int r = y; r < ye; r++)
            for (int c = x; c < xe; c++)
                frame_mem[r*DISP_W + c] = color;
    endfunction

    // Apply one command to the shadow framebuffer and return its result
    function automatic read_result_t apply_draw_command(draw_cmd_t c);
        read_result_t res;
        int           cols;
        res = '0;
        case (c.kind)
            KIND_FILL:
                for (int i = 0; i < DISP_W*DISP_H; i++)
                    frame_mem[i] = c.pixel_color;
            KIND_PIXEL:
                plot_pixel(int'(c.pos_x), int'(c.pos_y), c.pixel_color);
            KIND_RECT:
                paint_block(int'(c.pos_x), int'(c.pos_y), int'(c.rect_width),
                            int'(c.rect_height), c.pixel_color);
            KIND_DIAMOND:
                for (int r = 0; r < 6; r++)
                    paint_block(int'(c.pos_x) + DIAMOND_OFF[r], int'(c.pos_y) + r,
                                DIAMOND_LEN[r], 1, c.pixel_color);
            KIND_GLYPH:
            begin
                cols = int'((font_width_q > GLYPH_COLS_MAX) ? GLYPH_COLS_MAX : font_width_q);
                for (int i = 0; i < cols; i++)
                    if (c.glyph_bits[MASK_W-1-i])
                        plot_pixel(int'(c.pos_x) + i, int'(c.pos_y), c.pixel_color);
            end
            KIND_READ:
                if (c.pos_x < DISP_W && c.pos_y < DISP_H)
                begin
                    res.value    = frame_mem[c.pos_y*DISP_W + c.pos_x];
                    res.in_range = 1'b1;
                end
            default: ;
        endcase
        return res;
    endfunction

    // Pick a coordinate: mostly inside, often on the clipping edge, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_coord(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return POS_W'($urandom_range(0, span + 5));
        else if (r < 85)
            return POS_W'($urandom_range(span - 8, span + 8));
        else
            return POS_W'($urandom_range(0, 4095));
    endfunction

    // Build one random drawing command; reads favor pixels just drawn
    function automatic draw_cmd_t make_command();
        draw_cmd_t c;
        int        pick;
        int        sz;
        c.pos_x       = pick_coord(DISP_W);
        c.pos_y       = pick_coord(DISP_H);
        c.rect_width  = POS_W'($urandom_range(0, 4095));
        c.rect_height = POS_W'($urandom_range(0, 4095));
        c.pixel_color = COLOR_W'($urandom_range(0, 65535));
        c.glyph_bits  = MASK_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 20)
            c.kind = KIND_PIXEL;
        else if (pick < 40)
            c.kind = KIND_RECT;
        else if (pick < 55)
            c.kind = KIND_DIAMOND;
        else if (pick < 75)
            c.kind = KIND_GLYPH;
        else if (pick < 97)
            c.kind = KIND_READ;
        else
            c.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;

        // Keep most rectangles small so the run stays short
        if (c.kind == KIND_RECT)
        begin
            sz = $urandom_range(0, 99);
            if (sz < 80)
            begin
                c.rect_width  = POS_W'($urandom_range(0, 12));
                c.rect_height = POS_W'($urandom_range(0, 12));
            end
            else if (sz < 88)
                c.rect_height = POS_W'($urandom_range(0, 3));
            else if (sz < 96)
                c.rect_width  = POS_W'($urandom_range(0, 3));
        end

        if (c.kind == KIND_READ)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                c.pos_x = POS_W'(last_draw_x + $urandom_range(0, 5));
                c.pos_y = POS_W'(last_draw_y + $urandom_range(0, 5));
            end
        end
        else if (c.kind != KIND_SPARE_LO && c.kind != KIND_SPARE_HI)
        begin
            last_draw_x = c.pos_x;
            last_draw_y = c.pos_y;
        end
        return c;
    endfunction

    task automatic queue_command(logic [KIND_W-1:0] kind, int x, int y, int w, int h,
                                 logic [COLOR_W-1:0] color, logic [MASK_W-1:0] mask);
        draw_cmd_t c;
        c.kind        = kind;
        c.pos_x       = POS_W'(x);
        c.pos_y       = POS_W'(y);
        c.rect_width  = POS_W'(w);
        c.rect_height = POS_W'(h);
        c.pixel_color = color;
        c.glyph_bits  = mask;
        draw_cmds_pending.push_back(c);
    endtask

    // Hold until every command is sent and every result has come back
    task automatic wait_until_drained();
        while (draw_cmds_pending.size() != 0 || cmd_ch.valid || read_results_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic void note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // Command driver: offer queued items, predict each accepted one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_gap = 0;
        end
        else
        begin
            cmd_taken = cmd_ch.valid && cmd_ch.ready;
            if (cmd_taken)
            begin
                read_results_due.push_back(apply_draw_command(cmd_cur));
                if ($urandom_range(0, 39) == 0)
                    cmd_burst = !cmd_burst;
                cmd_gap = cmd_burst ? 0 : $urandom_range(0, 7);
            end
            else if (!cmd_ch.valid && cmd_gap != 0)
                cmd_gap--;

            if ((cmd_taken || !cmd_ch.valid) && cmd_gap == 0 && draw_cmds_pending.size() != 0)
            begin
                cmd_cur = draw_cmds_pending.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.kind        <= cmd_cur.kind;
                cmd_ch.pos_x       <= cmd_cur.pos_x;
                cmd_ch.pos_y       <= cmd_cur.pos_y;
                cmd_ch.rect_width  <= cmd_cur.rect_width;
                cmd_ch.rect_height <= cmd_cur.rect_height;
                cmd_ch.pixel_color <= cmd_cur.pixel_color;
                cmd_ch.glyph_bits  <= cmd_cur.glyph_bits;
            end
            else if (cmd_taken)
                cmd_ch.valid <= 1'b0;
        end
    end

    // Result monitor: check each item against the oldest prediction, pace ready
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_wait = $urandom_range(0, 7);
        end
        else
        begin
            if (rsp_stall_seen != rsp_stall_reqs)
            begin
                rsp_stall_seen = rsp_stall_reqs;
                rsp_stall_left = RSP_STALL_LEN;
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (read_results_due.size() == 0)
                    note_mismatch("result with nothing due", 0, int'(rsp_ch.read_value));
                else
                begin
                    read_result_t want;
                    want = read_results_due.pop_front();
                    if (rsp_ch.read_value !== want.value)
                        note_mismatch("read_value", int'(want.value),
                                      int'(rsp_ch.read_value));
                    if (rsp_ch.read_in_range !== want.in_range)
                        note_mismatch("read_in_range", int'(want.in_range),
                                      int'(rsp_ch.read_in_range));
                end
                if ($urandom_range(0, 39) == 0)
                    rsp_burst = !rsp_burst;
                rsp_wait = rsp_burst ? 0 : $urandom_range(0, 7);
            end
            else if (!rsp_ch.ready && rsp_wait != 0)
                rsp_wait--;

            // Hold ready low through a requested long stall
            if (rsp_stall_left != 0)
            begin
                rsp_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= (rsp_wait == 0);
        end
    end

    // Watchdog: stop when no item moves on either channel for too long
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int font_plan [PHASES];

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = FONT_WIDTH_RESET;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = '0;
        cmd_ch.pos_x       = '0;
        cmd_ch.pos_y       = '0;
        cmd_ch.rect_width  = '0;
        cmd_ch.rect_height = '0;
        cmd_ch.pixel_color = '0;
        cmd_ch.glyph_bits  = '0;
        rsp_ch.ready       = 1'b0;
        font_width_q       = FONT_WIDTH_RESET;
        mismatch_count     = 0;
        idle_cycles        = 0;
        rsp_stall_reqs     = 0;
        rsp_stall_seen     = 0;
        rsp_stall_left     = 0;
        cmd_burst          = 1'b0;
        rsp_burst          = 1'b0;
        last_draw_x        = '0;
        last_draw_y        = '0;

        // Font widths per phase: reset value, zero, the extremes, and random picks
        font_plan[0] = int'(FONT_WIDTH_RESET);
        font_plan[1] = 0;
        font_plan[2] = 16;
        font_plan[3] = 31;
        font_plan[4] = 1;
        font_plan[5] = 17;
        font_plan[6] = $urandom_range(2, 15);
        font_plan[7] = $urandom_range(0, 31);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                wait_until_drained();
                repeat (8) @(posedge clk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= FONT_W'(font_plan[phase]);
                @(posedge clk);
                cfg_wr_en    <= 1'b0;
                font_width_q = FONT_W'(font_plan[phase]);
                @(negedge clk);
            end

            if (phase == 0)
            begin
                // Fill first so that every later in-range read hits a written pixel
                queue_command(KIND_FILL,    0,    0,    0,    0,    16'h1234, 16'h0000);
                queue_command(KIND_READ,    0,    0,    0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_READ,    159,  127,  0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_READ,    160,  0,    0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_READ,    0,    128,  0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_READ,    4095, 4095, 0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_PIXEL,   0,    0,    0,    0,    16'hFFFF, 16'h0000);
                queue_command(KIND_READ,    0,    0,    0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_PIXEL,   159,  127,  0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_READ,    159,  127,  0,    0,    16'h0000, 16'h0000);
                // Off-screen writes drop silently; a rectangle past the corner is clipped
                queue_command(KIND_PIXEL,   160,  5,    0,    0,    16'hFFFF, 16'h0000);
                queue_command(KIND_PIXEL,   4095, 4095, 4095, 4095, 16'hFFFF, 16'hFFFF);
                queue_command(KIND_RECT,    150,  120,  4095, 4095, 16'hF800, 16'h0000);
                queue_command(KIND_READ,    159,  127,  0,    0,    16'h0000, 16'h0000);
                // Empty rectangles
                queue_command(KIND_RECT,    10,   10,   0,    5,    16'h07E0, 16'h0000);
                queue_command(KIND_RECT,    10,   10,   5,    0,    16'h07E0, 16'h0000);
                queue_command(KIND_READ,    10,   10,   0,    0,    16'h0000, 16'h0000);
                // Diamonds clipped at the corner and fully off-screen
                queue_command(KIND_DIAMOND, 156,  124,  0,    0,    16'h001F, 16'h0000);
                queue_command(KIND_READ,    158,  126,  0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_DIAMOND, 4095, 4095, 0,    0,    16'h001F, 16'h0000);
                // Glyph rows ending at the right edge and starting at the left edge
                queue_command(KIND_GLYPH,   152,  3,    0,    0,    16'hABCD, 16'hFFFF);
                queue_command(KIND_READ,    159,  3,    0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_GLYPH,   0,    4,    0,    0,    16'h5A5A, 16'h8001);
                queue_command(KIND_READ,    0,    4,    0,    0,    16'h0000, 16'h0000);
                queue_command(KIND_SPARE_LO, 4095, 4095, 4095, 4095, 16'hFFFF, 16'hFFFF);
                queue_command(KIND_SPARE_HI, 4095, 4095, 4095, 4095, 16'hFFFF, 16'hFFFF);
            end

            if (phase == 2 || phase == 5)
                queue_command(KIND_FILL, 0, 0, 0, 0, COLOR_W'($urandom_range(0, 65535)),
                              16'h0000);

            // Stall the receiver for a long stretch while commands keep coming
            if (phase == 1)
                rsp_stall_reqs++;

            for (int i = 0; i < ITEMS_PER_HALF; i++)
                draw_cmds_pending.push_back(make_command());

            // Pause the sender until the engine has drained
            wait_until_drained();

            for (int i = 0; i < ITEMS_PER_HALF; i++)
                draw_cmds_pending.push_back(make_command());
        end

        wait_until_drained();
        repeat (30) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== framebuffer_draw_engine_core.f =====
rtl/core/fde_pkg.sv
rtl/core/fde_if.sv
rtl/core/fde_ram.sv
rtl/core/fde_front.sv
rtl/core/fde_queue.sv
rtl/core/fde_back.sv
rtl/core/framebuffer_draw_engine_core.sv
rtl/core/fde_checker.sv
tb/tb_framebuffer_draw_engine_core.sv
